@@ sv/multi_server_drop_tail_queue_assert.svh @@
// Assertion macros used by the port checks.
`ifndef MULTI_SERVER_DROP_TAIL_QUEUE_ASSERT_SVH
`define MULTI_SERVER_DROP_TAIL_QUEUE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define MSQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/msdtq_pkg.sv @@
// ----------------------------------------------------------------------------
// msdtq_pkg
// Types and constants of the multi-server drop-tail queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msdtq_pkg;

    localparam logic [1:0] CFG_MAX_QUEUE    = 2'd0;
    localparam logic [1:0] CFG_WORKER_COUNT = 2'd1;
    localparam logic [1:0] CFG_CPU_CORES    = 2'd2;
    localparam logic [1:0] CFG_SERVICE_TIME = 2'd3;

    localparam logic [1:0] EV_ACCEPTED = 2'd0;
    localparam logic [1:0] EV_DROPPED  = 2'd1;
    localparam logic [1:0] EV_FINISHED = 2'd2;
    localparam logic [1:0] EV_SUMMARY  = 2'd3;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        command;
        logic [15:0] request_id;
        logic [31:0] now_time;
        logic [15:0] elapsed;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] request_id_out;
        logic [31:0] wait_time;
        logic [17:0] busy_time;
        logic [6:0]  queue_depth;
        logic [3:0]  busy_workers;
        logic [3:0]  pool_size;
        logic [31:0] received_count;
        logic [31:0] completed_count;
        logic [31:0] dropped_count;
        logic        last;
    } out_item_t;

    // Request to the shared divider and its answer.
    typedef struct packed {
        logic        start;
        logic [21:0] dividend;
        logic [3:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [21:0] quotient;
    } div_rsp_t;

endpackage

@@ sv/msdtq_divider.sv @@
// ----------------------------------------------------------------------------
// msdtq_divider
// Restoring divider, one quotient bit per cycle, for the service charge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msdtq_divider
    import msdtq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [21:0] quo_reg;
    logic [21:0] quo_next;
    logic [4:0]  rem_reg;
    logic [4:0]  rem_next;
    logic [3:0]  dvs_reg;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [4:0]  trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[3:0], quo_reg[21]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            cnt_next  = 5'd21;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[20:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[20:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (req.start)
        begin
            dvs_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ sv/multi_server_drop_tail_queue.sv @@
// ----------------------------------------------------------------------------
// multi_server_drop_tail_queue
// Request dispatcher with a bounded FIFO and a pool of worker slots.
// ----------------------------------------------------------------------------
// For an arrive beat, the request is written into the FIFO
// memory or dropped in the cycle after it is taken, one result beat
// (accepted or dropped) is shown on the next cycle, and the block is ready
// again on the cycle after that beat is taken.
// A tick beat is worked by a small sequencer that visits the worker slots one
// at a time. The resize phase adds or removes one slot at a time and then
// moves on. The advance pass visits every slot of the pool; finished
// requests are only noted there, and their result beats are shown later.
// The hand-out pass then skips each busy slot it visits, and each request
// handed out goes through a FIFO memory read, the charge and the
// placement. When contention scaling applies and the 5/2 cap is not reached,
// a hand-out also waits for the shared bit-serial divider. The pass ends
// when the FIFO runs empty, the limit of finished beats is reached or the
// last slot is visited. Finally the result beats (finished requests, then the
// summary) are loaded one at a time, and the block is ready again on the cycle
// after the summary beat is taken.
// The block is not ready for input while one item is at work. Configuration
// writes are always taken and should be made only while the block is idle.
// The FIFO memory has no reset; its entries are read only after being
// written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_server_drop_tail_queue
    import msdtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_WORKERS = 8,
    parameter int TIME_WIDTH  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int PW = $clog2(MAX_WORKERS + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ARRIVE  = 4'd1;
    localparam logic [3:0] S_RESIZE  = 4'd2;
    localparam logic [3:0] S_ADVANCE = 4'd3;
    localparam logic [3:0] S_FIN_OUT = 4'd4;
    localparam logic [3:0] S_PROMOTE = 4'd5;
    localparam logic [3:0] S_READ    = 4'd6;
    localparam logic [3:0] S_CHARGE  = 4'd7;
    localparam logic [3:0] S_DIVWAIT = 4'd8;
    localparam logic [3:0] S_PLACE   = 4'd9;
    localparam logic [3:0] S_SUMMARY = 4'd10;
    localparam logic [3:0] S_OUTWAIT = 4'd11;

    // Configuration registers.
    logic [6:0]  max_queue_reg;
    logic [3:0]  worker_count_reg;
    logic [3:0]  cpu_cores_reg;
    logic [15:0] service_time_reg;

    // FIFO memory.
    logic [15:0]           fifo_ids [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] fifo_arrival [QUEUE_DEPTH];
    logic [15:0]           rd_id_reg;
    logic [TIME_WIDTH-1:0] rd_arr_reg;
    logic [CW-1:0]         fifo_count_reg;
    logic [QW-1:0]         fifo_head_reg;

    // Worker slots.
    logic [MAX_WORKERS-1:0] slot_busy_reg;
    logic [15:0]            slot_request [MAX_WORKERS];
    logic [17:0]            slot_remaining [MAX_WORKERS];
    logic [17:0]            slot_total [MAX_WORKERS];
    logic [31:0]            slot_wait [MAX_WORKERS];
    logic [PW-1:0]          pool_reg;

    logic [31:0] acc_reg;
    logic [31:0] fin_reg;
    logic [31:0] drop_reg;

    logic [3:0]    state_reg;
    in_item_t      item_reg;
    logic [SW-1:0] idx_reg;
    logic [PW-1:0] fin_cnt_reg;
    logic [PW-1:0] busy_cnt_reg;
    logic [31:0]   wait_reg;
    logic [17:0]   charge_reg;

    logic        out_valid_reg;
    out_item_t   out_reg;
    logic        out_load;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Saturated target and capacity.
    logic [PW-1:0] target;
    logic [CW-1:0] cap;
    logic [PW-1:0] busy_now;
    logic [TIME_WIDTH-1:0] now_t;
    logic [QW-1:0] tail;
    logic [QW:0]   tail_sum;
    logic          last_idx;
    logic [QW-1:0] head_inc;

    always_comb
    begin
        if (worker_count_reg == 4'd0)
        begin
            target = PW'(1);
        end
        else if (32'(worker_count_reg) > 32'(MAX_WORKERS))
        begin
            target = PW'(MAX_WORKERS);
        end
        else
        begin
            target = PW'(worker_count_reg);
        end
        if (32'(max_queue_reg) > 32'(QUEUE_DEPTH))
        begin
            cap = CW'(QUEUE_DEPTH);
        end
        else
        begin
            cap = CW'(max_queue_reg);
        end
        busy_now = '0;
        for (int i = 0; i < MAX_WORKERS; i++)
        begin
            if (slot_busy_reg[i])
            begin
                busy_now = busy_now + PW'(1);
            end
        end
        now_t    = TIME_WIDTH'(item_reg.now_time);
        tail_sum = (QW + 1)'(fifo_head_reg) + (QW + 1)'(fifo_count_reg);
        if (32'(tail_sum) >= 32'(QUEUE_DEPTH))
        begin
            tail = QW'(32'(tail_sum) - 32'(QUEUE_DEPTH));
        end
        else
        begin
            tail = QW'(tail_sum);
        end
        if (32'(fifo_head_reg) == QUEUE_DEPTH - 1)
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = fifo_head_reg + QW'(1);
        end
        last_idx = (32'(idx_reg) + 1 >= 32'(pool_reg));
    end

    // A result beat is loaded on an arrive, and during the replay whenever
    // the output register is empty or being taken.
    assign out_load  = (state_reg == S_ARRIVE) ||
                       ((state_reg == S_SUMMARY) && (!out_valid_reg || out_ready));
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    msdtq_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    // Charge: base when cores is zero or busy <= cores, else base*busy/cores, or base*5/2 above 5/2.
    logic        scale;
    logic        cap_hit;
    logic [17:0] cap_charge;
    always_comb
    begin
        scale      = (cpu_cores_reg != 4'd0) && (32'(busy_cnt_reg) > 32'(cpu_cores_reg));
        cap_hit    = (32'(busy_cnt_reg) * 2) > (32'(cpu_cores_reg) * 5);
        cap_charge = 18'((20'(service_time_reg) * 20'd5) >> 1);
        div_req.start    = (state_reg == S_CHARGE) && scale && !cap_hit;
        div_req.dividend = 22'(service_time_reg) * 22'(busy_cnt_reg);
        div_req.divisor  = cpu_cores_reg;
    end

    // Builds a whole result beat; busy and pool counts are taken as they
    // stand, since neither changes while result beats are shown.
    function automatic out_item_t mk(input logic [1:0] kind, input logic [15:0] id,
                                     input logic [31:0] wt, input logic [17:0] bt,
                                     input logic [6:0] qd, input logic [31:0] rc,
                                     input logic [31:0] cc, input logic [31:0] dc,
                                     input logic lst);
        out_item_t o;
        o = '0;
        o.event_kind      = kind;
        o.request_id_out  = id;
        o.wait_time       = wt;
        o.busy_time       = bt;
        o.queue_depth     = qd;
        o.busy_workers    = 4'(busy_now);
        o.pool_size       = 4'(pool_reg);
        o.received_count  = rc;
        o.completed_count = cc;
        o.dropped_count   = dc;
        o.last            = lst;
        return o;
    endfunction

    // The step-wide counts are the ones that stand after the whole step. A
    // finished beat is held back and shown once the step is over, so every
    // beat carries final counts: finished beats are queued in a small
    // register file and replayed in the summary phase.
    logic [15:0]   fq_id   [MAX_WORKERS];
    logic [31:0]   fq_wait [MAX_WORKERS];
    logic [17:0]   fq_busy [MAX_WORKERS];
    logic [PW-1:0] rp_reg;

    function automatic logic [31:0] sat(input logic [31:0] c);
        return (c == SAT_MAX) ? c : c + 32'd1;
    endfunction

    // The head entry is captured once, while the head still points at it.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ARRIVE && fifo_count_reg < cap)
        begin
            fifo_ids[tail]     <= item_reg.request_id;
            fifo_arrival[tail] <= now_t;
        end
        if (state_reg == S_READ)
        begin
            rd_id_reg  <= fifo_ids[fifo_head_reg];
            rd_arr_reg <= fifo_arrival[fifo_head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_queue_reg    <= 7'd64;
            worker_count_reg <= 4'd1;
            cpu_cores_reg    <= 4'd0;
            service_time_reg <= 16'd0;
            fifo_count_reg   <= '0;
            fifo_head_reg    <= '0;
            slot_busy_reg    <= '0;
            pool_reg         <= '0;
            acc_reg          <= '0;
            fin_reg          <= '0;
            drop_reg         <= '0;
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            idx_reg          <= '0;
            fin_cnt_reg      <= '0;
            busy_cnt_reg     <= '0;
            rp_reg           <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MAX_QUEUE:    max_queue_reg    <= cfg_data[6:0];
                    CFG_WORKER_COUNT: worker_count_reg <= cfg_data[3:0];
                    CFG_CPU_CORES:    cpu_cores_reg    <= cfg_data[3:0];
                    CFG_SERVICE_TIME: service_time_reg <= cfg_data[15:0];
                    default:          ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_reg    <= in_data;
                        idx_reg     <= '0;
                        fin_cnt_reg <= '0;
                        rp_reg      <= '0;
                        state_reg   <= (in_data.command == CMD_ARRIVE) ? S_ARRIVE : S_RESIZE;
                    end
                end
                S_ARRIVE:
                begin
                    if (fifo_count_reg >= cap)
                    begin
                        drop_reg <= sat(drop_reg);
                        out_reg  <= mk(EV_DROPPED, item_reg.request_id, '0, '0,
                                       7'(fifo_count_reg), acc_reg, fin_reg,
                                       sat(drop_reg), 1'b1);
                    end
                    else
                    begin
                        fifo_count_reg <= fifo_count_reg + CW'(1);
                        acc_reg        <= sat(acc_reg);
                        out_reg  <= mk(EV_ACCEPTED, item_reg.request_id, '0, '0,
                                       7'(fifo_count_reg + CW'(1)), sat(acc_reg),
                                       fin_reg, drop_reg, 1'b1);
                    end
                    state_reg <= S_OUTWAIT;
                end
                S_RESIZE:
                begin
                    // One slot per cycle: grow, or drop an idle end slot.
                    if (pool_reg < target)
                    begin
                        slot_busy_reg[SW'(pool_reg)] <= 1'b0;
                        pool_reg <= pool_reg + PW'(1);
                    end
                    else if (pool_reg > target && !slot_busy_reg[SW'(pool_reg - PW'(1))])
                    begin
                        pool_reg <= pool_reg - PW'(1);
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        state_reg <= (pool_reg == '0) ? S_SUMMARY : S_ADVANCE;
                    end
                end
                S_ADVANCE:
                begin
                    if (slot_busy_reg[idx_reg])
                    begin
                        if (18'(item_reg.elapsed) >= slot_remaining[idx_reg])
                        begin
                            slot_busy_reg[idx_reg]  <= 1'b0;
                            slot_remaining[idx_reg] <= '0;
                            fin_reg <= sat(fin_reg);
                            fq_id[SW'(fin_cnt_reg)]   <= slot_request[idx_reg];
                            fq_wait[SW'(fin_cnt_reg)] <= slot_wait[idx_reg];
                            fq_busy[SW'(fin_cnt_reg)] <= slot_total[idx_reg];
                            fin_cnt_reg <= fin_cnt_reg + PW'(1);
                        end
                        else
                        begin
                            slot_remaining[idx_reg] <= slot_remaining[idx_reg]
                                                       - 18'(item_reg.elapsed);
                        end
                    end
                    if (last_idx)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_PROMOTE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                S_PROMOTE:
                begin
                    if (fifo_count_reg == '0 || 32'(fin_cnt_reg) >= MAX_WORKERS)
                    begin
                        state_reg <= S_SUMMARY;
                    end
                    else if (slot_busy_reg[idx_reg])
                    begin
                        if (last_idx)
                        begin
                            state_reg <= S_SUMMARY;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + SW'(1);
                        end
                    end
                    else
                    begin
                        busy_cnt_reg <= busy_now;
                        state_reg    <= S_READ;
                    end
                end
                S_READ:
                begin
                    fifo_head_reg  <= head_inc;
                    fifo_count_reg <= fifo_count_reg - CW'(1);
                    state_reg      <= S_CHARGE;
                end
                S_CHARGE:
                begin
                    wait_reg <= (now_t >= rd_arr_reg) ? 32'(now_t - rd_arr_reg) : 32'd0;
                    if (!scale)
                    begin
                        charge_reg <= 18'(service_time_reg);
                        state_reg  <= S_PLACE;
                    end
                    else if (cap_hit)
                    begin
                        charge_reg <= cap_charge;
                        state_reg  <= S_PLACE;
                    end
                    else
                    begin
                        state_reg <= S_DIVWAIT;
                    end
                end
                S_DIVWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        charge_reg <= div_rsp.quotient[17:0];
                        state_reg  <= S_PLACE;
                    end
                end
                S_PLACE:
                begin
                    if (charge_reg == '0)
                    begin
                        fin_reg <= sat(fin_reg);
                        fq_id[SW'(fin_cnt_reg)]   <= rd_id_reg;
                        fq_wait[SW'(fin_cnt_reg)] <= wait_reg;
                        fq_busy[SW'(fin_cnt_reg)] <= '0;
                        fin_cnt_reg <= fin_cnt_reg + PW'(1);
                    end
                    else
                    begin
                        slot_busy_reg[idx_reg]  <= 1'b1;
                        slot_request[idx_reg]   <= rd_id_reg;
                        slot_remaining[idx_reg] <= charge_reg;
                        slot_total[idx_reg]     <= charge_reg;
                        slot_wait[idx_reg]      <= wait_reg;
                    end
                    if (last_idx)
                    begin
                        state_reg <= S_SUMMARY;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + SW'(1);
                        state_reg <= S_PROMOTE;
                    end
                end
                S_SUMMARY:
                begin
                    // Replays the finished beats, then the summary beat.
                    if (out_load)
                    begin
                        if (rp_reg < fin_cnt_reg)
                        begin
                            out_reg <= mk(EV_FINISHED, fq_id[SW'(rp_reg)],
                                          fq_wait[SW'(rp_reg)], fq_busy[SW'(rp_reg)],
                                          7'(fifo_count_reg), acc_reg, fin_reg,
                                          drop_reg, 1'b0);
                            rp_reg <= rp_reg + PW'(1);
                        end
                        else
                        begin
                            out_reg   <= mk(EV_SUMMARY, '0, '0, '0,
                                            7'(fifo_count_reg), acc_reg, fin_reg,
                                            drop_reg, 1'b1);
                            state_reg <= S_OUTWAIT;
                        end
                    end
                end
                S_OUTWAIT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/msdtq_checker.sv @@
// ----------------------------------------------------------------------------
// msdtq_port_checks
// Port-level checks of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_server_drop_tail_queue_assert.svh"

module msdtq_port_checks
    import msdtq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // A stalled result beat holds.
    `MSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
    // Input is not taken while a result waits.
    `MSQ_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken while a result waits")
    // A summary beat always closes the step.
    `MSQ_ASSERT_IMP(a_summary_last, clk, rst_n, out_valid && out_data.event_kind == EV_SUMMARY, out_data.last, "summary beat not last")
    // Busy workers never exceed the pool.
    `MSQ_ASSERT_IMP(a_busy_pool, clk, rst_n, out_valid, out_data.busy_workers <= out_data.pool_size, "more busy workers than slots")

endmodule

bind multi_server_drop_tail_queue msdtq_port_checks u_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);

@@ tb/sv/msdtq_checker.sv @@
// ----------------------------------------------------------------------------
// msdtq_checker
// Watches the channels of the dispatcher, predicts every result beat and
// compares each one field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msdtq_checker
    import msdtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int DEPTH   = 64;
    localparam int WORKERS = 8;

    // Register copies.
    logic [6:0]  q_limit;
    logic [3:0]  worker_target;
    logic [3:0]  core_count;
    logic [15:0] base_service;

    // Dispatcher state as the block should hold it.
    logic [15:0] queued_id [DEPTH];
    logic [31:0] queued_at [DEPTH];
    int          q_count;
    int          q_head;
    logic        busy     [WORKERS];
    logic [15:0] serving  [WORKERS];
    logic [17:0] left     [WORKERS];
    logic [17:0] charged  [WORKERS];
    logic [31:0] waited   [WORKERS];
    int          pool;
    logic [31:0] n_received;
    logic [31:0] n_completed;
    logic [31:0] n_dropped;

    out_item_t expected_beats[$];

    function automatic int count_busy();
        int n;
        n = 0;
        for (int i = 0; i < pool; i++)
            if (busy[i])
                n++;
        return n;
    endfunction

    // Service time under contention, capped at 5/2 of the base.
    function automatic logic [17:0] service_for(int n_busy);
        int unsigned t;
        t = base_service;
        if (core_count != 0 && n_busy > core_count) begin
            if (2 * n_busy > 5 * core_count)
                t = (base_service * 5) / 2;
            else
                t = (base_service * n_busy) / core_count;
        end
        return t[17:0];
    endfunction

    function automatic logic [31:0] bump(logic [31:0] c);
        return (c == SAT_MAX) ? c : c + 1;
    endfunction

    function automatic out_item_t event_beat(logic [1:0] kind, logic [15:0] id,
                                             logic [31:0] w, logic [17:0] b);
        out_item_t r;
        r = '0;
        r.event_kind     = kind;
        r.request_id_out = id;
        r.wait_time      = w;
        r.busy_time      = b;
        return r;
    endfunction

    task automatic dispatch(input in_item_t item);
        out_item_t beats[$];
        out_item_t r;
        int cap, tail, target, n_done, dt;
        logic [15:0] id;
        logic [31:0] w;
        logic [17:0] t;
        if (item.command == CMD_ARRIVE) begin
            cap = (q_limit > DEPTH) ? DEPTH : q_limit;
            if (q_count >= cap) begin
                n_dropped = bump(n_dropped);
                beats.insert(beats.size(), event_beat(EV_DROPPED, item.request_id, '0, '0));
            end else begin
                tail = (q_head + q_count) % DEPTH;
                queued_id[tail] = item.request_id;
                queued_at[tail] = item.now_time;
                q_count++;
                n_received = bump(n_received);
                beats.insert(beats.size(), event_beat(EV_ACCEPTED, item.request_id, '0, '0));
            end
        end else begin
            target = (worker_target == 0) ? 1 : worker_target;
            if (target > WORKERS)
                target = WORKERS;
            dt = int'(item.elapsed);
            n_done = 0;
            while (pool < target) begin
                busy[pool] = 1'b0;
                pool++;
            end
            // Only idle slots at the end of the pool may go away.
            while (pool > target && !busy[pool-1])
                pool--;
            for (int i = 0; i < pool; i++) begin
                if (busy[i]) begin
                    if (dt >= left[i]) begin
                        busy[i] = 1'b0;
                        left[i] = '0;
                        n_completed = bump(n_completed);
                        beats.insert(beats.size(), event_beat(EV_FINISHED, serving[i],
                                                              waited[i], charged[i]));
                        n_done++;
                    end else begin
                        left[i] = left[i] - 18'(dt);
                    end
                end
            end
            // Idle slots take requests from the head, in index order, until
            // the per-tick limit on finished beats is reached.
            for (int i = 0; i < pool && q_count != 0; i++) begin
                if (!busy[i]) begin
                    if (n_done >= WORKERS)
                        break;
                    id = queued_id[q_head];
                    w  = (item.now_time >= queued_at[q_head]) ?
                         item.now_time - queued_at[q_head] : 32'd0;
                    q_head = (q_head + 1) % DEPTH;
                    q_count--;
                    t = service_for(count_busy());
                    if (t == 0) begin
                        n_completed = bump(n_completed);
                        beats.insert(beats.size(), event_beat(EV_FINISHED, id, w, '0));
                        n_done++;
                    end else begin
                        busy[i]    = 1'b1;
                        serving[i] = id;
                        left[i]    = t;
                        charged[i] = t;
                        waited[i]  = w;
                    end
                end
            end
            beats.insert(beats.size(), event_beat(EV_SUMMARY, '0, '0, '0));
        end
        foreach (beats[k]) begin
            r = beats[k];
            r.queue_depth     = q_count[6:0];
            r.busy_workers    = 4'(count_busy());
            r.pool_size       = pool[3:0];
            r.received_count  = n_received;
            r.completed_count = n_completed;
            r.dropped_count   = n_dropped;
            r.last            = (k == beats.size() - 1);
            expected_beats.insert(expected_beats.size(), r);
        end
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        errors++;
    endtask

    task automatic compare_beat(out_item_t got, out_item_t want);
        if (got.event_kind !== want.event_kind)
            report_mismatch("event_kind", got.event_kind, want.event_kind);
        if (got.request_id_out !== want.request_id_out)
            report_mismatch("request_id_out", got.request_id_out, want.request_id_out);
        if (got.wait_time !== want.wait_time)
            report_mismatch("wait_time", got.wait_time, want.wait_time);
        if (got.busy_time !== want.busy_time)
            report_mismatch("busy_time", got.busy_time, want.busy_time);
        if (got.queue_depth !== want.queue_depth)
            report_mismatch("queue_depth", got.queue_depth, want.queue_depth);
        if (got.busy_workers !== want.busy_workers)
            report_mismatch("busy_workers", got.busy_workers, want.busy_workers);
        if (got.pool_size !== want.pool_size)
            report_mismatch("pool_size", got.pool_size, want.pool_size);
        if (got.received_count !== want.received_count)
            report_mismatch("received_count", got.received_count, want.received_count);
        if (got.completed_count !== want.completed_count)
            report_mismatch("completed_count", got.completed_count, want.completed_count);
        if (got.dropped_count !== want.dropped_count)
            report_mismatch("dropped_count", got.dropped_count, want.dropped_count);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            q_limit       = 7'd64;
            worker_target = 4'd1;
            core_count    = 4'd0;
            base_service  = 16'd0;
            q_count       = 0;
            q_head        = 0;
            pool          = 0;
            n_received    = '0;
            n_completed   = '0;
            n_dropped     = '0;
            for (int i = 0; i < WORKERS; i++) begin
                busy[i]    = 1'b0;
                serving[i] = '0;
                left[i]    = '0;
                charged[i] = '0;
                waited[i]  = '0;
            end
            expected_beats.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_beats.size() == 0)
                    report_mismatch("unexpected beat, kind", out_data.event_kind, 0);
                else
                    compare_beat(out_data, expected_beats.pop_front());
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAX_QUEUE:    q_limit       = cfg_data[6:0];
                    CFG_WORKER_COUNT: worker_target = cfg_data[3:0];
                    CFG_CPU_CORES:    core_count    = cfg_data[3:0];
                    CFG_SERVICE_TIME: base_service  = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                dispatch(in_data);
            pending = expected_beats.size();
        end
    end

endmodule

@@ tb/sv/tb_multi_server_drop_tail_queue.sv @@
// ----------------------------------------------------------------------------
// tb_multi_server_drop_tail_queue
// Drives arrive and tick beats and register writes into the dispatcher; a
// checker beside it predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_server_drop_tail_queue;
    import msdtq_pkg::*;

    // Cycles without any accepted beat before the run is declared hung. The
    // slowest tick (eight scaled hand-outs through the serial divider plus
    // nine result beats, each held by the longest receiver gap) stays far below this.
    localparam int HANG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int          errors;
    int          pending;
    int          idle_cycles = 0;
    // When set, neither side inserts gaps, so beats run back to back.
    logic        calm;
    // Running time base so that arrivals and ticks form a plausible timeline.
    logic [31:0] clock_now;

    multi_server_drop_tail_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    msdtq_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hang detection: any accepted beat on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: before each result beat it holds ready low for a random
    // number of cycles, then keeps it high until a beat is taken.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Sends one beat. Called at a falling edge; returns at a falling edge
    // with valid still high, so back-to-back beats need no extra cycle.
    task automatic send_beat(input logic cmd, input logic [15:0] id,
                             input logic [31:0] at, input logic [15:0] dt);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.command    = cmd;
        in_data.request_id = id;
        in_data.now_time   = at;
        in_data.elapsed    = dt;
        in_valid           = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // An arrival at the current time plus a small skew.
    task automatic arrive(input logic [15:0] id);
        send_beat(CMD_ARRIVE, id, clock_now + $urandom_range(0, 3), 16'($urandom));
    endtask

    // A tick that moves the timeline forward by dt.
    task automatic tick(input logic [15:0] dt);
        clock_now = clock_now + 32'(dt);
        send_beat(CMD_TICK, 16'($urandom), clock_now, dt);
    endtask

    // Holds the sender until every predicted beat has been seen; every beat
    // causes at least one result, so nothing is still at work after that.
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [6:0] mq, input logic [3:0] wc,
                             input logic [3:0] cores, input logic [15:0] svc);
        drain();
        write_reg(CFG_MAX_QUEUE, 32'(mq));
        write_reg(CFG_WORKER_COUNT, 32'(wc));
        write_reg(CFG_CPU_CORES, 32'(cores));
        write_reg(CFG_SERVICE_TIME, 32'(svc));
    endtask

    initial
    begin
        int unsigned arrive_pct;
        int unsigned svc;
        logic [6:0]  mq;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_MAX_QUEUE;
        cfg_data    = '0;
        calm        = 1'b0;
        clock_now   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Tiny queue, pass-through service: one drop on overflow, and a
        // wait that clamps to zero when the tick time lies before arrival.
        configure(7'd2, 4'd1, 4'd0, 16'd0);
        send_beat(CMD_ARRIVE, 16'hFFFF, 32'd0, 16'hFFFF);
        send_beat(CMD_ARRIVE, 16'h0000, 32'd5, 16'h0000);
        send_beat(CMD_ARRIVE, 16'h1234, 32'd6, 16'd0);
        send_beat(CMD_TICK, 16'hFFFF, 32'd10, 16'd0);
        send_beat(CMD_TICK, 16'h0000, 32'd3, 16'hFFFF);

        // Capacity above depth, full pool, contention scaling up to its cap
        // with the largest service time; then the largest elapsed time.
        configure(7'd127, 4'd15, 4'd2, 16'hFFFF);
        for (int i = 0; i < 8; i++)
            send_beat(CMD_ARRIVE, 16'(16'hA000 + i), 32'hFFFF_FFF0, 16'd0);
        send_beat(CMD_TICK, 16'd0, 32'hFFFF_FFFF, 16'd0);
        send_beat(CMD_TICK, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);

        // Pool shrinks only past idle tail slots; the target of zero acts
        // as one and a core count above the pool never scales.
        configure(7'd64, 4'd0, 4'd15, 16'd1);
        send_beat(CMD_TICK, 16'd0, 32'd100, 16'd0);
        send_beat(CMD_TICK, 16'd0, 32'd200, 16'hFFFF);
        send_beat(CMD_TICK, 16'd0, 32'd300, 16'hFFFF);

        // More zero-time requests than the per-tick limit of finished beats.
        configure(7'd64, 4'd8, 4'd0, 16'd0);
        for (int i = 0; i < 10; i++)
            send_beat(CMD_ARRIVE, 16'(16'h5A00 + i), 32'd400, 16'd0);
        send_beat(CMD_TICK, 16'd0, 32'd500, 16'd7);
        send_beat(CMD_TICK, 16'd0, 32'd600, 16'd7);

        // Random phases. Each one rewrites every register while the block
        // is idle, then runs mostly a well-formed timeline with a share of
        // arbitrary times and elapsed values.
        for (int p = 0; p < 11; p++) begin
            case ($urandom_range(0, 4))
                0: mq = 7'd0;
                1: mq = 7'd64;
                2: mq = 7'($urandom_range(65, 127));
                default: mq = 7'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 3))
                0: svc = 0;
                1: svc = $urandom_range(0, 65535);
                default: svc = $urandom_range(1, 40);
            endcase
            configure(mq, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      16'(svc));
            calm = p[0];
            arrive_pct = $urandom_range(35, 70);
            for (int k = 0; k < 30; k++) begin
                if ($urandom_range(0, 99) < arrive_pct)
                    arrive(16'($urandom));
                else if ($urandom_range(0, 9) == 0)
                    send_beat(CMD_TICK, 16'($urandom), $urandom, 16'($urandom));
                else
                    tick(16'($urandom_range(0, (svc > 60) ? 60 : svc + 5)));
            end
        end
        calm = 1'b0;

        drain();
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
